### rtl/chacha_pkg.sv
// Package for the ChaCha20 stream cipher: word types, register indexes,
// controller/datapath command structs and the quarter-round half step.
// No dependencies.
`timescale 1ns / 1ps

package chacha_pkg;

  typedef logic [31:0] word_t;

  localparam int NumWords    = 16;
  localparam int BlockBytes  = 64;
  localparam int PosW        = 7;
  localparam int RoundSteps  = 40;  // 20 rounds, two half steps each
  localparam int StepCntW    = 6;

  localparam word_t Sigma0 = 32'h61707865;
  localparam word_t Sigma1 = 32'h3320646e;
  localparam word_t Sigma2 = 32'h79622d32;
  localparam word_t Sigma3 = 32'h6b206574;

  typedef enum logic [2:0] {
    REG_KEY0     = 3'd0,
    REG_KEY1     = 3'd1,
    REG_KEY2     = 3'd2,
    REG_KEY3     = 3'd3,
    REG_NONCE_LO = 3'd4,
    REG_NONCE_HI = 3'd5,
    REG_INIT_CTR = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic take_in;    // capture the accepted input byte
    logic load;       // load the working state from key, nonce and counter
    logic round;      // apply one half step of a column or diagonal round
    logic diag;       // diagonal round when set, column round otherwise
    logic half;       // second half of the quarter round when set
    logic final_add;  // add the original state in and bump the counter
    logic emit;       // write the result byte to the output register
  } dp_cmd_t;

  typedef struct packed {
    logic ks_empty;   // all 64 keystream bytes used
  } dp_status_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } qr_t;

  // One half of the quarter round: rotations 16/12 first, then 8/7.
  function automatic qr_t chacha_qr_half(input word_t a, input word_t b,
                                         input word_t c, input word_t d,
                                         input logic half);
    qr_t   r;
    word_t t;
    r.a = a + b;
    t   = d ^ r.a;
    r.d = half ? {t[23:0], t[31:24]} : {t[15:0], t[31:16]};
    r.c = c + r.d;
    t   = b ^ r.c;
    r.b = half ? {t[24:0], t[31:25]} : {t[19:0], t[31:20]};
    return r;
  endfunction

endpackage

### rtl/chacha_ctrl.sv
// Controller for the ChaCha20 stream cipher: handshakes, block generation
// sequencing and the round step counter. Depends on chacha_pkg.
`timescale 1ns / 1ps

module chacha_ctrl import chacha_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_ROUND = 5'b00100,
    S_FINAL = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t               state, state_next;
  logic [StepCntW-1:0]  step_cnt;
  logic                 accept;
  logic                 out_free;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.diag      = step_cnt[1];
    cmd.half      = step_cnt[0];
    case (state)
      S_IDLE: begin
        cmd.take_in = accept;
        if (accept) begin
          state_next = status.ks_empty ? S_LOAD : S_EMIT;
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (step_cnt == StepCntW'(RoundSteps - 1)) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.final_add = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = out_free;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ROUND) begin
        step_cnt <= step_cnt + 1'b1;
      end else begin
        step_cnt <= '0;
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

### rtl/chacha_dp.sv
// Datapath for the ChaCha20 stream cipher: configuration registers, block
// counter, working state with a shared half-round unit, keystream byte
// select and the output register. Depends on chacha_pkg.
`timescale 1ns / 1ps

module chacha_dp import chacha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata,
  input  logic [7:0]  s_tdata,
  output logic [7:0]  m_tdata,
  input  dp_cmd_t     cmd,
  output dp_status_t  status
);

  logic [63:0]     key0, key1, key2, key3, nonce_lo;
  logic [31:0]     nonce_hi, init_ctr;
  word_t           block_ctr;
  logic [PosW-1:0] pos;
  logic [7:0]      in_byte;
  word_t           work [NumWords];
  word_t           init [NumWords];
  word_t           work_next [NumWords];
  word_t           ks_word;
  logic [7:0]      ks_byte;
  logic            cfg_hit;
  logic [1:0]      lb, lc, ld;
  qr_t             q;

  assign cfg_hit = cfg_we && (cfg_addr <= 3'(REG_INIT_CTR));

  always_comb begin
    init[0]  = Sigma0;
    init[1]  = Sigma1;
    init[2]  = Sigma2;
    init[3]  = Sigma3;
    init[4]  = key0[31:0];
    init[5]  = key0[63:32];
    init[6]  = key1[31:0];
    init[7]  = key1[63:32];
    init[8]  = key2[31:0];
    init[9]  = key2[63:32];
    init[10] = key3[31:0];
    init[11] = key3[63:32];
    init[12] = block_ctr;
    init[13] = nonce_lo[31:0];
    init[14] = nonce_lo[63:32];
    init[15] = nonce_hi;
  end

  // Four quarter rounds side by side; the diagonal round rotates the lanes
  // of rows b, c and d by one, two and three words.
  always_comb begin
    work_next = work;
    lb = '0;
    lc = '0;
    ld = '0;
    q  = '0;
    for (int i = 0; i < 4; i++) begin
      lb = cmd.diag ? 2'(i + 1) : 2'(i);
      lc = cmd.diag ? 2'(i + 2) : 2'(i);
      ld = cmd.diag ? 2'(i + 3) : 2'(i);
      q  = chacha_qr_half(work[{2'd0, 2'(i)}], work[{2'd1, lb}],
                          work[{2'd2, lc}], work[{2'd3, ld}], cmd.half);
      work_next[{2'd0, 2'(i)}] = q.a;
      work_next[{2'd1, lb}]    = q.b;
      work_next[{2'd2, lc}]    = q.c;
      work_next[{2'd3, ld}]    = q.d;
    end
  end

  assign ks_word = work[pos[5:2]];

  always_comb begin
    case (pos[1:0])
      2'd0:    ks_byte = ks_word[7:0];
      2'd1:    ks_byte = ks_word[15:8];
      2'd2:    ks_byte = ks_word[23:16];
      default: ks_byte = ks_word[31:24];
    endcase
  end

  assign status.ks_empty = pos[PosW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key0      <= '0;
      key1      <= '0;
      key2      <= '0;
      key3      <= '0;
      nonce_lo  <= '0;
      nonce_hi  <= '0;
      init_ctr  <= '0;
      block_ctr <= '0;
      pos       <= PosW'(BlockBytes);
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_KEY0:     key0     <= cfg_wdata;
          REG_KEY1:     key1     <= cfg_wdata;
          REG_KEY2:     key2     <= cfg_wdata;
          REG_KEY3:     key3     <= cfg_wdata;
          REG_NONCE_LO: nonce_lo <= cfg_wdata;
          REG_NONCE_HI: nonce_hi <= cfg_wdata[31:0];
          REG_INIT_CTR: init_ctr <= cfg_wdata[31:0];
          default: ;
        endcase
      end
      // Any register write restarts the stream from the initial counter.
      if (cfg_hit) begin
        block_ctr <= (cfg_addr == 3'(REG_INIT_CTR)) ? cfg_wdata[31:0] : init_ctr;
        pos       <= PosW'(BlockBytes);
      end else if (cmd.final_add) begin
        block_ctr <= block_ctr + 32'd1;
        pos       <= '0;
      end else if (cmd.emit) begin
        pos <= pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      in_byte <= s_tdata;
    end
    if (cmd.emit) begin
      m_tdata <= in_byte ^ ks_byte;
    end
    for (int j = 0; j < NumWords; j++) begin
      if (cmd.load) begin
        work[j] <= init[j];
      end else if (cmd.round) begin
        work[j] <= work_next[j];
      end else if (cmd.final_add) begin
        work[j] <= work[j] + init[j];
      end
    end
  end

endmodule

### rtl/chacha20_stream_cipher.sv
// ChaCha20 stream cipher, one byte per transaction. Within a keystream block
// a byte is first accepted, then written to the result register once the
// output is free. Every 64th byte first builds a new block: a load, 40
// half-round steps of the shared half-round unit and one final add.
// Reset is synchronous and immediate: registers and counter go to zero and
// the keystream is marked used up.
`timescale 1ns / 1ps

module chacha20_stream_cipher import chacha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [7:0] data_out
);

  dp_cmd_t    cmd;
  dp_status_t status;

  chacha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  chacha_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

### sim/tb_chacha20_stream_cipher.sv
// Self-checking testbench for chacha20_stream_cipher: byte stream in, byte stream out.
// Depends on rtl/chacha_pkg.sv for the register indexes and the sigma constants.
// Runs a short directed table, then random key/nonce/counter phases under random flow control.
`timescale 1ns / 1ps

module tb_chacha20_stream_cipher;
  import chacha_pkg::*;

  localparam int          RandItems  = 1550;
  localparam int          CycleLimit = 600000;
  localparam logic [2:0]  REG_UNUSED = 3'd7;  // decoded by no register, must be ignored

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  addr;
    logic [63:0] wdata;
    logic [7:0]  din;
    logic        typed;   // dout holds a known answer instead of the predicted one
    logic [7:0]  dout;
  } dir_row_t;

  localparam int NumDirRows = 32;

  // The known answers come from the all-zero key, nonce and counter block.
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{ROW_ITEM, REG_KEY0,     64'd0,                  8'h00, 1'b1, 8'h76},
    '{ROW_ITEM, REG_KEY0,     64'd0,                  8'hFF, 1'b1, 8'h47},
    '{ROW_ITEM, REG_KEY0,     64'd0,                  8'h00, 1'b1, 8'he0},
    '{ROW_ITEM, REG_KEY0,     64'd0,                  8'hFF, 1'b1, 8'h52},
    '{ROW_ITEM, REG_KEY0,     64'd0,                  8'h55, 1'b0, 8'h00},
    '{ROW_ITEM, REG_KEY0,     64'd0,                  8'hAA, 1'b0, 8'h00},
    '{ROW_REG,  REG_UNUSED,   64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 8'h00},
    '{ROW_ITEM, REG_KEY0,     64'd0,                  8'h00, 1'b1, 8'h3d},
    '{ROW_REG,  REG_KEY0,     64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 8'h00},
    '{ROW_REG,  REG_KEY1,     64'd0,                  8'h00, 1'b0, 8'h00},
    '{ROW_REG,  REG_KEY2,     64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, 8'h00},
    '{ROW_REG,  REG_KEY3,     64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 8'h00},
    '{ROW_REG,  REG_NONCE_LO, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 8'h00},
    '{ROW_REG,  REG_NONCE_HI, 64'hA5A5_A5A5_FFFF_FFFF, 8'h00, 1'b0, 8'h00},
    '{ROW_REG,  REG_INIT_CTR, 64'h5A5A_5A5A_FFFF_FFFF, 8'h00, 1'b0, 8'h00},
    '{ROW_ITEM, REG_KEY0,     64'd0,                  8'h00, 1'b0, 8'h00},
    '{ROW_ITEM, REG_KEY0,     64'd0,                  8'hFF, 1'b0, 8'h00},
    '{ROW_ITEM, REG_KEY0,     64'd0,                  8'h80, 1'b0, 8'h00},
    '{ROW_ITEM, REG_KEY0,     64'd0,                  8'h01, 1'b0, 8'h00},
    '{ROW_REG,  REG_INIT_CTR, 64'h1,                  8'h00, 1'b0, 8'h00},
    '{ROW_ITEM, REG_KEY0,     64'd0,                  8'h00, 1'b0, 8'h00},
    '{ROW_ITEM, REG_KEY0,     64'd0,                  8'h7F, 1'b0, 8'h00},
    '{ROW_REG,  REG_INIT_CTR, 64'h1,                  8'h00, 1'b0, 8'h00},
    '{ROW_ITEM, REG_KEY0,     64'd0,                  8'h00, 1'b0, 8'h00},
    '{ROW_REG,  REG_KEY0,     64'd0,                  8'h00, 1'b0, 8'h00},
    '{ROW_REG,  REG_KEY2,     64'd0,                  8'h00, 1'b0, 8'h00},
    '{ROW_REG,  REG_KEY3,     64'd0,                  8'h00, 1'b0, 8'h00},
    '{ROW_REG,  REG_NONCE_LO, 64'd0,                  8'h00, 1'b0, 8'h00},
    '{ROW_REG,  REG_NONCE_HI, 64'd0,                  8'h00, 1'b0, 8'h00},
    '{ROW_REG,  REG_INIT_CTR, 64'd0,                  8'h00, 1'b0, 8'h00},
    '{ROW_ITEM, REG_KEY0,     64'd0,                  8'h00, 1'b1, 8'h76},
    '{ROW_ITEM, REG_KEY0,     64'd0,                  8'h00, 1'b1, 8'hb8}
  };

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_addr  = '0;
  logic [63:0] cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;   // [7:0] data_in
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;          // [7:0] data_out

  chacha20_stream_cipher u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Cipher state as the testbench sees it.
  logic [63:0] key_r [4] = '{64'd0, 64'd0, 64'd0, 64'd0};
  logic [63:0] nonce_lo_r = '0;
  word_t       nonce_hi_r = '0;
  word_t       ctr_init_r = '0;
  word_t       blk_ctr    = '0;
  logic [7:0]  ks_buf [64];
  int unsigned ks_pos     = BlockBytes;
  word_t       mix_st [NumWords];

  logic [7:0]  exp_cipher_q [$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned burst_left   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void qr_mix(input int ia, input int ib, input int ic, input int id);
    word_t a, b, c, d;
    a = mix_st[ia]; b = mix_st[ib]; c = mix_st[ic]; d = mix_st[id];
    a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
    c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
    a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
    c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
    mix_st[ia] = a; mix_st[ib] = b; mix_st[ic] = c; mix_st[id] = d;
  endfunction

  function automatic void next_keystream_block();
    word_t init_w [NumWords];
    word_t v;
    int    i;
    init_w[0]  = Sigma0;
    init_w[1]  = Sigma1;
    init_w[2]  = Sigma2;
    init_w[3]  = Sigma3;
    for (i = 0; i < 4; i++) begin
      init_w[4 + 2 * i] = key_r[i][31:0];
      init_w[5 + 2 * i] = key_r[i][63:32];
    end
    init_w[12] = blk_ctr;
    init_w[13] = nonce_lo_r[31:0];
    init_w[14] = nonce_lo_r[63:32];
    init_w[15] = nonce_hi_r;
    for (i = 0; i < NumWords; i++) mix_st[i] = init_w[i];
    for (i = 0; i < 10; i++) begin
      qr_mix(0, 4, 8, 12);
      qr_mix(1, 5, 9, 13);
      qr_mix(2, 6, 10, 14);
      qr_mix(3, 7, 11, 15);
      qr_mix(0, 5, 10, 15);
      qr_mix(1, 6, 11, 12);
      qr_mix(2, 7, 8, 13);
      qr_mix(3, 4, 9, 14);
    end
    for (i = 0; i < NumWords; i++) begin
      v = mix_st[i] + init_w[i];
      ks_buf[4 * i]     = v[7:0];
      ks_buf[4 * i + 1] = v[15:8];
      ks_buf[4 * i + 2] = v[23:16];
      ks_buf[4 * i + 3] = v[31:24];
    end
    blk_ctr = blk_ctr + 32'd1;  // wraps silently past all ones
    ks_pos  = 0;
  endfunction

  function automatic logic [7:0] cipher_byte(input logic [7:0] din);
    logic [7:0] r;
    if (ks_pos >= BlockBytes) next_keystream_block();
    r = din ^ ks_buf[ks_pos];
    ks_pos++;
    return r;
  endfunction

  function automatic void apply_reg_write(input logic [2:0] addr, input logic [63:0] data);
    case (addr)
      REG_KEY0:     key_r[0]   = data;
      REG_KEY1:     key_r[1]   = data;
      REG_KEY2:     key_r[2]   = data;
      REG_KEY3:     key_r[3]   = data;
      REG_NONCE_LO: nonce_lo_r = data;
      REG_NONCE_HI: nonce_hi_r = data[31:0];
      REG_INIT_CTR: ctr_init_r = data[31:0];
      default:      return;
    endcase
    blk_ctr = ctr_init_r;
    ks_pos  = BlockBytes;
  endfunction

  // Registers may only change once every outstanding byte has come back.
  task automatic write_reg(input logic [2:0] addr, input logic [63:0] data);
    if (!cfg_we) begin
      s_tvalid <= 1'b0;
      while (exp_cipher_q.size() != 0) @(posedge clk);
      repeat (3) @(posedge clk);
    end
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    apply_reg_write(addr, data);
  endtask

  task automatic send_byte(input logic [7:0] din, input logic typed, input logic [7:0] dout);
    int unsigned gap;
    logic [7:0]  predicted;
    if (cfg_we) cfg_we <= 1'b0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= din;
    do @(posedge clk); while (!s_tready);
    predicted = cipher_byte(din);
    exp_cipher_q.push_back(typed ? dout : predicted);
  endtask

  // Receiver flow control: the pattern follows bits 9:8 of the cycle counter.
  always @(posedge clk) begin
    case (cycle_cnt[9:8])
      2'd0:    m_tready <= 1'b1;
      2'd1:    m_tready <= 1'($urandom_range(0, 1));
      2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (cycle_cnt % 7 < 3);
    endcase
  end

  always @(posedge clk) begin
    logic [7:0] e;
    if (!rst && m_tvalid && m_tready) begin
      if (exp_cipher_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected output transaction, data_out %02h", m_tdata);
      end else begin
        e = exp_cipher_q.pop_front();
        if (m_tdata !== e) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("data_out mismatch: expected %02h, got %02h", e, m_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned rnd_items;
    int unsigned phase_len;
    int unsigned n_writes;
    logic [2:0]  ra;
    logic [63:0] rv;
    rnd_items = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < NumDirRows; r++) begin
      if (DirRows[r].kind == ROW_REG) write_reg(DirRows[r].addr, DirRows[r].wdata);
      else send_byte(DirRows[r].din, DirRows[r].typed, DirRows[r].dout);
    end

    // The first phase starts at the top counter value so the block counter wraps.
    write_reg(REG_INIT_CTR, 64'hFFFF_FFFF);
    phase_len = 150;
    while (1) begin
      repeat (phase_len) send_byte(8'($urandom_range(0, 255)), 1'b0, 8'h00);
      rnd_items += phase_len;
      if (rnd_items >= RandItems) break;
      n_writes = $urandom_range(1, 3);
      repeat (n_writes) begin
        ra = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
          0:       rv = '0;
          1:       rv = '1;
          default: rv = {$urandom(), $urandom()};
        endcase
        if (ra == REG_INIT_CTR && $urandom_range(0, 2) == 0)
          rv = {$urandom(), 32'hFFFF_FFFF - 32'($urandom_range(0, 1))};
        write_reg(ra, rv);
      end
      phase_len = ($urandom_range(0, 7) == 0) ? $urandom_range(130, 300)
                                              : $urandom_range(1, 140);
    end

    s_tvalid <= 1'b0;
    while (exp_cipher_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_cnt == 0 && exp_cipher_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
